>>> rtl/lrs16k_pkg.sv
`timescale 1ns / 1ps

package lrs16k_pkg;

    // Field and register widths
    localparam int SAMPLE_W   = 16;
    localparam int RATE_W     = 18;
    localparam int LEN_W      = 25;
    localparam int PHASE_W    = 40;

    // Conversion constants
    localparam int OUT_RATE   = 16000;
    localparam int RATE_MIN   = 1000;
    localparam int RESULT_CAP = 32;

    // Serial datapath widths
    localparam int FRAC_W     = $clog2(OUT_RATE);
    localparam int Q_W        = SAMPLE_W;
    localparam int NUM_W      = $clog2(OUT_RATE * (2 ** (Q_W - 1))) + 1;
    localparam int ACC_W      = NUM_W + 2;
    localparam int CNT_W      = $clog2((FRAC_W > Q_W) ? FRAC_W : Q_W);

    // Configuration port
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = LEN_W;
    localparam logic [CFG_IDX_W-1:0] CFG_INPUT_RATE  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_CLIP_LENGTH = 1'b1;

    typedef logic signed [SAMPLE_W-1:0] sample_t;
    typedef logic [FRAC_W-1:0]          frac_t;

    typedef struct packed {
        logic    start;
        sample_t prev;
        sample_t cur;
        frac_t   frac;
    } lerp_req_t;

    typedef struct packed {
        logic    done;
        sample_t sample;
    } lerp_rsp_t;

endpackage

>>> rtl/lrs16k_if.sv
`timescale 1ns / 1ps

interface lrs16k_in_if import lrs16k_pkg::*; ();
    logic    valid;
    logic    ready;
    sample_t in_sample;

    modport source (output valid, output in_sample, input ready);
    modport sink   (input valid, input in_sample, output ready);
endinterface

interface lrs16k_out_if import lrs16k_pkg::*; ();
    logic    valid;
    logic    ready;
    sample_t out_sample;
    logic    run_end;
    logic    clip_end;

    modport source (output valid, output out_sample, output run_end, output clip_end,
                    input ready);
    modport sink   (input valid, input out_sample, input run_end, input clip_end,
                    output ready);
endinterface

>>> rtl/lrs16k_lerp.sv
`timescale 1ns / 1ps

// Bit-serial interpolator: shift-add multiply of the step by the fraction,
// then restoring division by the output rate, one quotient bit a cycle.
module lrs16k_lerp import lrs16k_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  lerp_req_t req,
    output lerp_rsp_t rsp
);

    localparam logic [NUM_W-1:0] DVS_INIT = NUM_W'(OUT_RATE * (2 ** (Q_W - 1)));

    logic                    busy_reg;
    logic                    div_phase_reg;
    logic [CNT_W-1:0]        cnt_reg;
    logic                    done_reg;
    logic signed [ACC_W-1:0] acc_reg;
    logic signed [ACC_W-1:0] mcand_reg;
    frac_t                   frac_sh_reg;
    logic [NUM_W-1:0]        dvs_reg;
    logic [Q_W-1:0]          quot_reg;
    sample_t                 sample_reg;

    logic [SAMPLE_W-1:0]     offs;
    logic [NUM_W-1:0]        base;
    logic signed [SAMPLE_W:0] step;
    logic                    ge;
    logic [Q_W-1:0]          quot_next;

    // Offset-binary left sample, scaled, plus half a divisor for rounding
    assign offs      = {~req.prev[SAMPLE_W-1], req.prev[SAMPLE_W-2:0]};
    assign base      = NUM_W'(offs) * NUM_W'(OUT_RATE) + NUM_W'(OUT_RATE / 2);
    assign step      = {req.cur[SAMPLE_W-1], req.cur} - {req.prev[SAMPLE_W-1], req.prev};
    assign ge        = acc_reg[NUM_W-1:0] >= dvs_reg;
    assign quot_next = {quot_reg[Q_W-2:0], ge};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            div_phase_reg <= 1'b0;
            cnt_reg       <= '0;
            done_reg      <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg      <= 1'b1;
                div_phase_reg <= 1'b0;
                cnt_reg       <= CNT_W'(FRAC_W - 1);
            end
            else if (busy_reg)
            begin
                if (cnt_reg == '0)
                begin
                    if (div_phase_reg)
                    begin
                        busy_reg <= 1'b0;
                        done_reg <= 1'b1;
                    end
                    else
                    begin
                        div_phase_reg <= 1'b1;
                        cnt_reg       <= CNT_W'(Q_W - 1);
                    end
                end
                else
                begin
                    cnt_reg <= cnt_reg - CNT_W'(1);
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            acc_reg     <= $signed({2'b00, base});
            mcand_reg   <= {{(ACC_W - SAMPLE_W - 1){step[SAMPLE_W]}}, step};
            frac_sh_reg <= req.frac;
        end
        else if (busy_reg && !div_phase_reg)
        begin
            if (frac_sh_reg[0])
            begin
                acc_reg <= acc_reg + mcand_reg;
            end
            mcand_reg   <= mcand_reg <<< 1;
            frac_sh_reg <= frac_sh_reg >> 1;
            if (cnt_reg == '0)
            begin
                dvs_reg <= DVS_INIT;
            end
        end
        else if (busy_reg)
        begin
            if (ge)
            begin
                acc_reg <= acc_reg - $signed({2'b00, dvs_reg});
            end
            quot_reg <= quot_next;
            dvs_reg  <= dvs_reg >> 1;
            if (cnt_reg == '0)
            begin
                sample_reg <= {~quot_next[Q_W-1], quot_next[Q_W-2:0]};
            end
        end
    end

    assign rsp.done   = done_reg;
    assign rsp.sample = sample_reg;

    a_start_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        req.start |-> !busy_reg)
        else $error("interpolator started while busy");

    a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.done |=> !rsp.done)
        else $error("interpolator done held for more than one cycle");

    a_done_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.done |-> !busy_reg)
        else $error("interpolator done while still busy");

endmodule

>>> rtl/linear_resampler_to_16k.sv
// Each accepted sample passes ST_PREP and ST_LIMIT into ST_CHECK; a held output
// leaves from ST_CHECK, while an interpolated one is made in ST_FRAC and ST_LERP first.
// A new sample is taken only in ST_IDLE, once every result of the last one has moved
// to the output register; the bit-serial interpolator takes 14 multiply steps, 16 divide steps.
// Reset: asynchronous, active low; clears all clip state and the handshakes and
// returns input_rate to 48000 and clip_length to 16000.
`timescale 1ns / 1ps

module linear_resampler_to_16k import lrs16k_pkg::*;
#(
    parameter int MAX_CLIP_SAMPLES = 16777216
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    lrs16k_in_if.sink             feed,
    lrs16k_out_if.source          result
);

    localparam int IDX_W = (MAX_CLIP_SAMPLES > 1) ? $clog2(MAX_CLIP_SAMPLES) : 1;
    localparam int N_W   = $clog2(RESULT_CAP + 1);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_PREP  = 3'd1;
    localparam logic [2:0] ST_LIMIT = 3'd2;
    localparam logic [2:0] ST_CHECK = 3'd3;
    localparam logic [2:0] ST_FRAC  = 3'd4;
    localparam logic [2:0] ST_LERP  = 3'd5;

    // Configuration registers
    logic [RATE_W-1:0]  input_rate_reg;
    logic [LEN_W-1:0]   clip_length_reg;

    // Clip state
    sample_t            prev_reg;
    logic [IDX_W-1:0]   index_reg;
    logic [PHASE_W-1:0] phase_reg;
    logic [PHASE_W-1:0] ib_reg;

    // Per-item working registers
    logic [2:0]         state_reg;
    logic [2:0]         state_next;
    logic [N_W-1:0]     n_reg;
    sample_t            cur_reg;
    logic [PHASE_W-1:0] limit_reg;
    logic [PHASE_W-1:0] left_pos_reg;
    logic               final_reg;
    logic [PHASE_W:0]   diff_reg;

    // Result waiting for its run_end flag, and the output register
    logic               pend_valid_reg;
    sample_t            pend_sample_reg;
    logic               pend_clip_reg;
    logic               out_valid_reg;
    sample_t            out_sample_reg;
    logic               out_run_end_reg;
    logic               out_clip_end_reg;

    logic [RATE_W-1:0]  rate_eff;
    logic [RATE_W:0]    two_rate;
    logic [LEN_W-1:0]   len_eff;
    logic [PHASE_W:0]   pos_next;
    logic [PHASE_W:0]   pos_two;
    logic [PHASE_W:0]   diff;
    logic               fits;
    logic               lagging;
    logic               emit;
    logic               out_free;
    logic               proceed;
    logic               load_out;
    frac_t              frac_sel;
    lerp_req_t          lerp_req;
    lerp_rsp_t          lerp_rsp;

    // Clamp the registers into their working ranges
    assign rate_eff = (input_rate_reg < RATE_W'(RATE_MIN)) ? RATE_W'(RATE_MIN)
                                                            : input_rate_reg;
    assign two_rate = {rate_eff, 1'b0};
    assign len_eff  = (clip_length_reg == '0) ? LEN_W'(1) :
                      (clip_length_reg > LEN_W'(MAX_CLIP_SAMPLES)) ?
                      LEN_W'(MAX_CLIP_SAMPLES) : clip_length_reg;

    // Position tests for the output at phase_reg: does it exist, and is it the
    // last of the clip. Both sums keep the carry so a lowered limit stays safe.
    assign pos_next = {1'b0, phase_reg} + {{(PHASE_W + 1 - RATE_W){1'b0}}, rate_eff};
    assign pos_two  = {1'b0, phase_reg} + {{(PHASE_W - RATE_W){1'b0}}, two_rate};
    assign diff     = {1'b0, phase_reg} - {1'b0, left_pos_reg};
    assign fits     = pos_next <= {1'b0, limit_reg};
    assign lagging  = phase_reg < ib_reg;

    // An output before the incoming sample interpolates (never on the first
    // sample of a clip); one at or past it holds the sample, final sample only.
    assign emit     = (n_reg != N_W'(RESULT_CAP)) && fits &&
                      (lagging ? (index_reg != '0) : final_reg);

    // The waiting result leaves only once the next decision has fixed run_end
    assign out_free = !out_valid_reg || result.ready;
    assign proceed  = !pend_valid_reg || out_free;
    assign load_out = (state_reg == ST_CHECK) && pend_valid_reg && out_free;

    // Fraction: zero when lagging behind the left sample, capped below one
    assign frac_sel = diff_reg[PHASE_W] ? '0 :
                      (diff_reg[PHASE_W-1:0] >= PHASE_W'(OUT_RATE)) ?
                      FRAC_W'(OUT_RATE - 1) : diff_reg[FRAC_W-1:0];

    assign lerp_req.start = (state_reg == ST_FRAC);
    assign lerp_req.prev  = prev_reg;
    assign lerp_req.cur   = cur_reg;
    assign lerp_req.frac  = frac_sel;

    lrs16k_lerp u_lerp (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (lerp_req),
        .rsp   (lerp_rsp)
    );

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (feed.valid)
                begin
                    state_next = ST_PREP;
                end
            end
            ST_PREP:  state_next = ST_LIMIT;
            ST_LIMIT: state_next = ST_CHECK;
            ST_CHECK:
            begin
                if (proceed)
                begin
                    if (!emit)
                    begin
                        state_next = ST_IDLE;
                    end
                    else if (lagging)
                    begin
                        state_next = ST_FRAC;
                    end
                end
            end
            ST_FRAC:  state_next = ST_LERP;
            ST_LERP:
            begin
                if (lerp_rsp.done)
                begin
                    state_next = ST_CHECK;
                end
            end
            default:  state_next = ST_IDLE;
        endcase
    end

    // Configuration writes; the user must issue them only while the block is idle, as the block does not enforce it
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            input_rate_reg  <= RATE_W'(48000);
            clip_length_reg <= LEN_W'(16000);
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_INPUT_RATE:  input_rate_reg  <= cfg_data[RATE_W-1:0];
                CFG_CLIP_LENGTH: clip_length_reg <= cfg_data;
                default:         ;
            endcase
        end
    end

    // Control and clip state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            n_reg          <= '0;
            pend_valid_reg <= 1'b0;
            prev_reg       <= '0;
            index_reg      <= '0;
            phase_reg      <= '0;
            ib_reg         <= '0;
        end
        else
        begin
            state_reg <= state_next;
            case (state_reg)
                ST_PREP:
                begin
                    n_reg <= '0;
                end
                ST_CHECK:
                begin
                    if (proceed)
                    begin
                        // A held output refills the waiting slot at once; any other outcome empties it
                        pend_valid_reg <= emit && !lagging;
                        if (emit)
                        begin
                            phase_reg <= pos_next[PHASE_W-1:0];
                            n_reg     <= n_reg + N_W'(1);
                        end
                        else if (final_reg)
                        begin
                            // Clip done: start the next one from scratch
                            prev_reg  <= '0;
                            index_reg <= '0;
                            phase_reg <= '0;
                            ib_reg    <= '0;
                        end
                        else
                        begin
                            prev_reg  <= cur_reg;
                            index_reg <= index_reg + IDX_W'(1);
                            ib_reg    <= ib_reg + PHASE_W'(OUT_RATE);
                        end
                    end
                end
                ST_LERP:
                begin
                    if (lerp_rsp.done)
                    begin
                        pend_valid_reg <= 1'b1;
                    end
                end
                default: ;
            endcase
        end
    end

    // Per-item payload
    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
            begin
                if (feed.valid)
                begin
                    cur_reg <= feed.in_sample;
                end
            end
            ST_PREP:
            begin
                limit_reg    <= {{(PHASE_W - LEN_W){1'b0}}, len_eff} * PHASE_W'(OUT_RATE);
                final_reg    <= ({{(LEN_W - IDX_W){1'b0}}, index_reg} + LEN_W'(1)) >= len_eff;
                left_pos_reg <= (ib_reg >= PHASE_W'(OUT_RATE)) ?
                                ib_reg - PHASE_W'(OUT_RATE) : '0;
            end
            ST_LIMIT:
            begin
                limit_reg <= limit_reg + PHASE_W'(rate_eff >> 1);
            end
            ST_CHECK:
            begin
                if (proceed && emit)
                begin
                    pend_clip_reg <= pos_two > {1'b0, limit_reg};
                    diff_reg      <= diff;
                    if (!lagging)
                    begin
                        pend_sample_reg <= cur_reg;
                    end
                end
            end
            ST_LERP:
            begin
                if (lerp_rsp.done)
                begin
                    pend_sample_reg <= lerp_rsp.sample;
                end
            end
            default: ;
        endcase
    end

    // Output register: refill from the waiting result, else drain on transfer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (load_out)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            out_sample_reg   <= pend_sample_reg;
            out_run_end_reg  <= !emit;
            out_clip_end_reg <= pend_clip_reg;
        end
    end

    assign feed.ready        = (state_reg == ST_IDLE);
    assign result.valid      = out_valid_reg;
    assign result.out_sample = out_sample_reg;
    assign result.run_end    = out_run_end_reg;
    assign result.clip_end   = out_clip_end_reg;

    a_idle_nothing_waiting: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> !pend_valid_reg)
        else $error("result left waiting after item completed");

    a_result_cap: assert property (@(posedge clk) disable iff (!rst_n)
        n_reg <= N_W'(RESULT_CAP))
        else $error("more results than the per-item cap");

    a_lerp_result_kept: assert property (@(posedge clk) disable iff (!rst_n)
        lerp_rsp.done |=> pend_valid_reg)
        else $error("interpolated result not captured");

endmodule

>>> tb/linear_resampler_to_16k_tb.sv
`timescale 1ns / 1ps

module linear_resampler_to_16k_tb import lrs16k_pkg::*; ();

    localparam int MAX_CLIP_SAMPLES = 16777216;
    localparam int RANDOM_ITEMS     = 100;
    // Cycles to let pass after the last expected output before touching the
    // registers, so that an item that yields nothing has surely left the block.
    localparam int SETTLE_CYCLES    = 40;
    // Receiver hold-off used once to back the block up into its input.
    localparam int SQUEEZE_CYCLES   = 600;
    localparam int CYCLE_LIMIT      = 2000000;
    localparam longint unsigned PHASE_MASK = (64'd1 << PHASE_W) - 1;

    // One 16 kHz output as it should appear on the result channel
    typedef struct packed {
        sample_t sample;
        logic    run_end;
        logic    clip_end;
    } resampled_t;

    // Tracks registers and clip state, predicts the outputs of every
    // accepted sample and checks the outputs that come back, in order.
    class resample_tracker;
        logic [RATE_W-1:0]  rate_reg;
        logic [LEN_W-1:0]   length_reg;
        sample_t            prev_sample;
        logic [23:0]        sample_index;
        logic [PHASE_W-1:0] phase_acc;
        logic [PHASE_W-1:0] interval_base;
        resampled_t         outputs_due[$];
        int                 mismatches;

        function new();
            rate_reg      = 18'd48000;
            length_reg    = 25'd16000;
            prev_sample   = '0;
            sample_index  = '0;
            phase_acc     = '0;
            interval_base = '0;
            mismatches    = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
            if (idx == CFG_INPUT_RATE)
                rate_reg = val[RATE_W-1:0];
            else if (idx == CFG_CLIP_LENGTH)
                length_reg = val[LEN_W-1:0];
        endfunction

        function longint unsigned clip_len();
            longint unsigned len;
            len = length_reg;
            if (len == 0)
                len = 1;
            if (len > MAX_CLIP_SAMPLES)
                len = MAX_CLIP_SAMPLES;
            return len;
        endfunction

        function longint unsigned samples_to_clip_end();
            longint unsigned len;
            len = clip_len();
            return (sample_index >= len) ? 1 : len - sample_index;
        endfunction

        function sample_t interpolate(sample_t a, sample_t b, longint unsigned frac);
            longint num;
            longint q;
            num = longint'(a) * OUT_RATE + (longint'(b) - longint'(a)) * longint'(frac);
            q   = (num + longint'(32768) * OUT_RATE + OUT_RATE / 2) / OUT_RATE;
            return sample_t'(q - 32768);
        endfunction

        function void accept_sample(sample_t cur);
            longint unsigned rate;
            longint unsigned len;
            longint unsigned limit;
            longint unsigned left_pos;
            longint unsigned frac;
            longint unsigned ph;
            longint unsigned bs;
            bit              last_in_clip;
            int              n;
            resampled_t      r;
            rate = (rate_reg < RATE_MIN) ? RATE_MIN : rate_reg;
            len  = clip_len();
            limit = len * OUT_RATE + rate / 2;
            last_in_clip = (longint'(sample_index) + 1 >= len);
            ph = phase_acc;
            bs = interval_base;
            left_pos = (bs >= OUT_RATE) ? bs - OUT_RATE : 0;
            n = 0;
            while (n < RESULT_CAP && ph + rate <= limit)
            begin
                if (ph < bs)
                begin
                    // no left neighbour yet on the first sample of a clip
                    if (sample_index == 0)
                        break;
                    // a lagging position clamps to the left sample
                    frac = (ph >= left_pos) ? ph - left_pos : 0;
                    if (frac >= OUT_RATE)
                        frac = OUT_RATE - 1;
                    r.sample = interpolate(prev_sample, cur, frac);
                end
                else
                begin
                    if (!last_in_clip)
                        break;
                    r.sample = cur;
                end
                r.run_end  = 1'b0;
                r.clip_end = (ph + 2 * rate > limit);
                outputs_due = {outputs_due, r};
                ph = (ph + rate) & PHASE_MASK;
                n++;
            end
            if (n > 0)
            begin
                r = outputs_due.pop_back();
                r.run_end = 1'b1;
                outputs_due = {outputs_due, r};
            end
            if (last_in_clip)
            begin
                prev_sample   = '0;
                sample_index  = '0;
                phase_acc     = '0;
                interval_base = '0;
            end
            else
            begin
                phase_acc     = ph[PHASE_W-1:0];
                prev_sample   = cur;
                sample_index  = sample_index + 1'b1;
                interval_base = interval_base + OUT_RATE;
            end
        endfunction

        function void check_output(sample_t sample, logic run_end, logic clip_end);
            resampled_t exp_out;
            if (outputs_due.size() == 0)
            begin
                if (mismatches < 10)
                    $display("unexpected output: sample %0d run_end %0b clip_end %0b",
                             sample, run_end, clip_end);
                mismatches++;
            end
            else
            begin
                exp_out = outputs_due.pop_front();
                if (sample !== exp_out.sample || run_end !== exp_out.run_end
                    || clip_end !== exp_out.clip_end)
                begin
                    if (mismatches < 10)
                        $display("output mismatch: expected %0d/%0b/%0b, got %0d/%0b/%0b",
                                 exp_out.sample, exp_out.run_end, exp_out.clip_end,
                                 sample, run_end, clip_end);
                    mismatches++;
                end
            end
        endfunction

        function int pending();
            return outputs_due.size();
        endfunction
    endclass

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    lrs16k_in_if  feed_if ();
    lrs16k_out_if result_if ();

    resample_tracker tracker;
    bit              no_idle;
    bit              squeeze_req;
    int              cycles;

    linear_resampler_to_16k #(
        .MAX_CLIP_SAMPLES (MAX_CLIP_SAMPLES)
    ) u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .feed      (feed_if),
        .result    (result_if)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Mostly full-range random samples, now and then a rail value
    function automatic sample_t random_sample();
        case ($urandom_range(0, 7))
            0:       return 16'sh7FFF;
            1:       return 16'sh8000;
            default: return sample_t'($urandom);
        endcase
    endfunction

    // Offer one sample after a random gap and hold it until the transfer.
    // Enter and leave on a falling edge; valid is only lowered when a gap
    // follows, so it never toggles twice in one step.
    task automatic push_sample(input sample_t s);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 10);
        if (gap > 0)
        begin
            feed_if.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        feed_if.valid     <= 1'b1;
        feed_if.in_sample <= s;
        do
            @(posedge clk);
        while (!feed_if.ready);
        tracker.accept_sample(s);
        @(negedge clk);
    endtask

    // Drop valid, then wait until every predicted output has arrived and the
    // block has had time to finish any item that yields nothing.
    task automatic drain_block();
        feed_if.valid <= 1'b0;
        while (tracker.pending() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // Register write: enable high for exactly one rising edge
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        tracker.write_reg(idx, val);
        @(negedge clk);
        cfg_we <= 1'b0;
        @(negedge clk);
    endtask

    // Receiver: draw a stall per output, or hold off for a long stretch
    // once when asked, then take the next transfer and check it.
    initial
    begin : receiver
        int stall;
        @(posedge rst_n);
        @(negedge clk);
        forever
        begin
            stall = no_idle ? 0 : $urandom_range(0, 10);
            if (squeeze_req)
            begin
                stall = SQUEEZE_CYCLES;
                squeeze_req = 1'b0;
            end
            if (stall > 0)
            begin
                result_if.ready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            result_if.ready <= 1'b1;
            do
                @(posedge clk);
            while (!result_if.valid);
            tracker.check_output(result_if.out_sample, result_if.run_end,
                                 result_if.clip_end);
            @(negedge clk);
        end
    end

    // Watchdog: give up well past the slowest correct run
    initial
    begin : watchdog
        cycles = 0;
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("Mismatches found");
        $finish;
    end

    initial
    begin : stimulus
        int              random_items;
        int              burst;
        longint unsigned left;
        rst_n             = 1'b0;
        cfg_we            = 1'b0;
        cfg_index         = CFG_INPUT_RATE;
        cfg_data          = '0;
        feed_if.valid     = 1'b0;
        feed_if.in_sample = '0;
        result_if.ready   = 1'b0;
        no_idle           = 1'b0;
        squeeze_req       = 1'b0;
        random_items      = 0;
        tracker = new();

        repeat (4) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Reset values: 48 kHz, long clip; the second sample yields the first
        // output at fraction zero.
        push_sample(16'sh7FFF);
        push_sample(16'sh8000);
        drain_block();

        // Shorten the clip under way, so that the next sample closes it
        write_reg(CFG_INPUT_RATE, 25'd1000);
        write_reg(CFG_CLIP_LENGTH, 25'd3);
        push_sample(16'sh1111);
        drain_block();

        // Lowest rate, rail to rail: full interpolation sweep, then the held
        // tail on the final sample, exactly at the per-item output cap
        push_sample(16'sh8000);
        push_sample(16'sh7FFF);
        push_sample(16'sh0000);
        drain_block();

        // Rate below range acts as the minimum, zero length acts as one
        write_reg(CFG_INPUT_RATE, 25'd0);
        write_reg(CFG_CLIP_LENGTH, 25'd0);
        push_sample(16'sd12345);
        drain_block();
        write_reg(CFG_INPUT_RATE, 25'd999);
        write_reg(CFG_CLIP_LENGTH, 25'd1);
        push_sample(-16'sd4321);
        drain_block();

        // Highest rate on a short clip leaves the phase stuck; then drop to
        // the lowest rate with an over-range length: lagging outputs at
        // fraction zero, and more outputs due than one item may carry
        write_reg(CFG_INPUT_RATE, 25'd192000);
        write_reg(CFG_CLIP_LENGTH, 25'd5);
        push_sample(16'sh0100);
        push_sample(16'sh4000);
        push_sample(-16'sh4000);
        drain_block();
        write_reg(CFG_INPUT_RATE, 25'd1000);
        write_reg(CFG_CLIP_LENGTH, 25'h1FFFFFF);
        push_sample(16'sh7FFF);
        push_sample(16'sh8000);
        push_sample(16'sh2AAA);
        drain_block();

        // Widest rate register value, closing the long clip
        write_reg(CFG_INPUT_RATE, 25'h003FFFF);
        write_reg(CFG_CLIP_LENGTH, 25'd1);
        push_sample(16'sh5555);
        drain_block();

        // Clip too short for any output, then one output on a rounding tie
        write_reg(CFG_INPUT_RATE, 25'd192000);
        push_sample(16'sh0F0F);
        drain_block();
        write_reg(CFG_INPUT_RATE, 25'd32000);
        push_sample(-16'sd1);
        drain_block();
        write_reg(CFG_INPUT_RATE, 25'd24000);
        write_reg(CFG_CLIP_LENGTH, 25'd2);
        push_sample(16'sh7FFE);
        push_sample(16'sh8001);
        drain_block();

        // Back-pressure: the receiver holds off while the sender keeps
        // offering a dense upsampled clip, so the block fills and stalls
        write_reg(CFG_INPUT_RATE, 25'd1000);
        write_reg(CFG_CLIP_LENGTH, 25'd30);
        no_idle     = 1'b1;
        squeeze_req = 1'b1;
        repeat (30) push_sample(random_sample());
        no_idle = 1'b0;
        drain_block();

        // Random phases: new settings between bursts, mostly whole clips
        while (random_items < RANDOM_ITEMS)
        begin
            if ($urandom_range(0, 9) < 7)
            begin
                case ($urandom_range(0, 9))
                    0:       write_reg(CFG_INPUT_RATE, 25'd1000);
                    1:       write_reg(CFG_INPUT_RATE, 25'd192000);
                    2:       write_reg(CFG_INPUT_RATE, 25'($urandom_range(0, 999)));
                    3:       write_reg(CFG_INPUT_RATE, 25'($urandom));
                    4:       write_reg(CFG_INPUT_RATE, 25'd16000);
                    5:       write_reg(CFG_INPUT_RATE, 25'd44100);
                    default: write_reg(CFG_INPUT_RATE, 25'($urandom_range(1000, 192000)));
                endcase
            end
            if ($urandom_range(0, 9) < 7)
            begin
                case ($urandom_range(0, 11))
                    0:       write_reg(CFG_CLIP_LENGTH, 25'd0);
                    1:       write_reg(CFG_CLIP_LENGTH, 25'($urandom));
                    2:       write_reg(CFG_CLIP_LENGTH, 25'd1);
                    default: write_reg(CFG_CLIP_LENGTH, 25'($urandom_range(1, 24)));
                endcase
            end
            no_idle = ($urandom_range(0, 4) == 0);
            // Finish the clip under way most of the time; otherwise break
            // off mid-clip so the next settings land in the middle of one
            left = tracker.samples_to_clip_end();
            if ($urandom_range(0, 4) != 0 && left <= 40)
                burst = int'(left);
            else
                burst = $urandom_range(1, 20);
            repeat (burst)
            begin
                push_sample(random_sample());
                random_items++;
            end
            no_idle = 1'b0;
            drain_block();
        end

        if (tracker.mismatches == 0 && tracker.pending() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
